// ===== hdl/ist_pkg.sv =====
package ist_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [4:0] element_count;
    } t_out_item;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic             remove_go;
        logic             insert_go;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== hdl/integer_set_table.sv =====
// integer_set_table: a bounded set of signed 32-bit integers, insertion ordered.
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one request per
// item: insert, remove or membership query on i_in_item.value.
// Output channel (o_out_valid / i_out_ready / o_out_item) returns exactly one
// result item per request: status, found flag and element count after it.
// The table is a row of cells, one entry each; all cells compare against the
// request at once, and on remove every cell at or past the match copies its
// right neighbor, closing the gap in the same cycle.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one item per cycle while the receiver keeps taking results.
// The output register decouples the sides; when the receiver stalls the
// result holds and o_in_ready drops until it is taken.
// Reset empties the table (count zero) and clears the output valid; entry
// contents need no clearing because only entries below the count are read.
module integer_set_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ist_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ist_pkg::t_out_item o_out_item
);
    import ist_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             accept;
    logic             hit;
    logic             full;
    t_status          status;
    t_cell_ctl        ctl;
    logic             hit_chain [CAPACITY+1];
    logic [VAL_W-1:0] data_row  [CAPACITY+1];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign hit  = hit_chain[CAPACITY];
    assign full = r_count >= CNT_W'(CAPACITY);

    // Decide the request outcome from the cell row's match.
    always_comb begin
        n_count = r_count;
        status  = ST_DONE;
        case (t_op'(i_in_item.opcode))
            OP_INSERT: begin
                if (hit) begin
                    status = ST_PRESENT;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (!hit) begin
                    status = ST_ABSENT;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                status = hit ? ST_DONE : ST_ABSENT;
            end
        endcase
    end

    always_comb begin
        ctl.value     = i_in_item.value;
        ctl.count     = r_count;
        ctl.insert_go = accept && (t_op'(i_in_item.opcode) == OP_INSERT) && !hit && !full;
        ctl.remove_go = accept && (t_op'(i_in_item.opcode) == OP_REMOVE) && hit;
    end

    assign hit_chain[0]        = 1'b0;
    assign data_row[CAPACITY]  = data_row[CAPACITY-1];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ist_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_ctl        (ctl),
            .i_hit_left   (hit_chain[g]),
            .i_data_right (data_row[g+1]),
            .o_hit_right  (hit_chain[g+1]),
            .o_data       (data_row[g])
        );
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (accept) begin
            n_out_valid         = 1'b1;
            n_out.status        = status;
            n_out.found         = hit;
            n_out.element_count = 5'(n_count);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= accept ? n_count : r_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== hdl/ist_cell.sv =====
module ist_cell (
    input  logic                      i_clk,
    input  logic [ist_pkg::IDX_W-1:0] i_index,
    input  ist_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_hit_left,
    input  logic [ist_pkg::VAL_W-1:0] i_data_right,
    output logic                      o_hit_right,
    output logic [ist_pkg::VAL_W-1:0] o_data
);
    import ist_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic [CNT_W-1:0] index_ext;
    logic             live;
    logic             hit_here;

    assign index_ext   = CNT_W'(i_index);
    assign live        = index_ext < i_ctl.count;
    assign hit_here    = live && (r_data == i_ctl.value);
    // Match at or left of this cell: on remove, pull the right neighbor in.
    assign o_hit_right = i_hit_left | hit_here;
    assign o_data      = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.remove_go && o_hit_right) begin
            r_data <= i_data_right;
        end else if (i_ctl.insert_go && (index_ext == i_ctl.count)) begin
            r_data <= i_ctl.value;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ist_pkg::*;

    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int         RAND_ITEMS = 150;
    localparam int         POOL_SIZE  = 24;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item result;
    } t_directed_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Typed expectation that travels with the item being offered.
    bit        row_typed  = 1'b0;
    t_out_item row_result = '0;

    int send_idle_pct = 36;
    int recv_idle_pct = 71;
    int mismatch_count = 0;

    logic [VAL_W-1:0] held_values [CAPACITY];
    int               held_count = 0;
    t_out_item        pending_results [$];
    t_directed_row    directed_rows [$];
    logic [VAL_W-1:0] value_pool [POOL_SIZE];

    integer_set_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    // Update the set with one request and return the result it should give.
    function automatic t_out_item apply_request(t_in_item req);
        int        pos;
        bit        hit;
        t_out_item res;
        pos = held_count;
        for (int i = 0; i < held_count; i++) begin
            if (pos == held_count && held_values[i] == req.value) begin
                pos = i;
            end
        end
        hit = (pos < held_count);
        if (req.opcode == OP_INSERT) begin
            if (hit) begin
                res.status = ST_PRESENT;
            end else if (held_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                held_values[held_count] = req.value;
                held_count++;
                res.status = ST_DONE;
            end
        end else if (req.opcode == OP_REMOVE) begin
            if (!hit) begin
                res.status = ST_ABSENT;
            end else begin
                for (int i = pos; i < held_count - 1; i++) begin
                    held_values[i] = held_values[i + 1];
                end
                held_count--;
                res.status = ST_DONE;
            end
        end else begin
            res.status = hit ? ST_DONE : ST_ABSENT;
        end
        res.found         = hit;
        res.element_count = 5'(held_count);
        return res;
    endfunction

    function automatic t_directed_row make_row(logic [1:0] op, logic [VAL_W-1:0] val,
                                               bit typed, logic [1:0] st, bit fnd, int cnt);
        t_directed_row row;
        row.req.opcode              = op;
        row.req.value               = val;
        row.typed                   = typed;
        row.result.status           = st;
        row.result.found            = fnd;
        row.result.element_count    = 5'(cnt);
        return row;
    endfunction

    task automatic report_field(string field, int expected_val, int actual_val);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch: expected %0d, got %0d",
                     $realtime, field, expected_val, actual_val);
        end
    endtask

    // Receiver: drop ready at random per the current idle rate.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict on every accepted request, check every accepted result.
    always @(posedge i_clk) begin
        t_out_item predicted;
        t_out_item oldest;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_field("unexpected result, status", -1, o_out_item.status);
                end else begin
                    oldest = pending_results.pop_front();
                    if (o_out_item.status !== oldest.status)
                        report_field("status", oldest.status, o_out_item.status);
                    if (o_out_item.found !== oldest.found)
                        report_field("found", oldest.found, o_out_item.found);
                    if (o_out_item.element_count !== oldest.element_count)
                        report_field("element_count", oldest.element_count,
                                     o_out_item.element_count);
                end
            end
            if (i_in_valid && o_in_ready) begin
                predicted = apply_request(i_in_item);
                pending_results.push_back(row_typed ? row_result : predicted);
            end
        end
    end

    task automatic offer_item(t_in_item req, bit typed, t_out_item result);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        row_typed  <= typed;
        row_result <= result;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Hold the sender off until every expected result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [1:0] pick_opcode(bit draining);
        int r;
        r = $urandom_range(0, 99);
        if (r < (draining ? 20 : 55)) return OP_INSERT;
        if (r < 75) return OP_REMOVE;
        if (r < 95) return OP_QUERY;
        return OP_SPARE;
    endfunction

    task automatic run_random(int count);
        t_in_item req;
        for (int n = 0; n < count; n++) begin
            // Alternate fill and drain stretches so the table hits full and empty.
            req.opcode = pick_opcode(((n / 30) % 2) == 1);
            if ($urandom_range(0, 99) < 85) begin
                req.value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                req.value = $urandom;
            end
            offer_item(req, 1'b0, '0);
        end
    endtask

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        directed_rows.push_back(make_row(OP_QUERY,  32'h0000_0000, 1, ST_ABSENT,  0, 0));
        directed_rows.push_back(make_row(OP_REMOVE, 32'h0000_0000, 1, ST_ABSENT,  0, 0));
        directed_rows.push_back(make_row(OP_INSERT, 32'h8000_0000, 1, ST_DONE,    0, 1));
        directed_rows.push_back(make_row(OP_INSERT, 32'h7fff_ffff, 1, ST_DONE,    0, 2));
        directed_rows.push_back(make_row(OP_INSERT, 32'h8000_0000, 1, ST_PRESENT, 1, 2));
        directed_rows.push_back(make_row(OP_SPARE,  32'h7fff_ffff, 1, ST_DONE,    1, 2));
        directed_rows.push_back(make_row(OP_REMOVE, 32'h8000_0000, 1, ST_DONE,    1, 1));
        directed_rows.push_back(make_row(OP_INSERT, 32'hffff_ffff, 0, ST_DONE,    0, 0));
        for (int k = 0; k < 14; k++) begin
            directed_rows.push_back(make_row(OP_INSERT, 32'(1) << k, 0, ST_DONE, 0, 0));
        end
        directed_rows.push_back(make_row(OP_INSERT, 32'h1234_5678, 1, ST_FULL,    0, 16));
        // Duplicate check wins over the full check.
        directed_rows.push_back(make_row(OP_INSERT, 32'h7fff_ffff, 1, ST_PRESENT, 1, 16));
        directed_rows.push_back(make_row(OP_REMOVE, 32'h0000_0010, 1, ST_DONE,    1, 15));
        directed_rows.push_back(make_row(OP_QUERY,  32'h0000_0010, 1, ST_ABSENT,  0, 15));
        directed_rows.push_back(make_row(OP_REMOVE, 32'h7fff_ffff, 1, ST_DONE,    1, 14));
        directed_rows.push_back(make_row(OP_INSERT, 32'h1234_5678, 1, ST_DONE,    0, 15));
        directed_rows.push_back(make_row(OP_SPARE,  32'h0000_2000, 1, ST_DONE,    1, 15));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            offer_item(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].result);
        end
        run_random(RAND_ITEMS);
        drain_results();

        send_idle_pct = 71;
        recv_idle_pct = 36;
        run_random(RAND_ITEMS);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RAND_ITEMS);
        drain_results();

        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
